// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Each macro checks one clocked implication, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define MMF_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define MMF_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/mmf_pkg.sv =====
// ----------------------------------------------------------------------------
// mmf_pkg
// Types and constants shared by the moving median filter modules.
// ----------------------------------------------------------------------------
package mmf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 5;

    localparam logic [CFG_W-1:0] HALF_WIDTH_RESET = CFG_W'(4);

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Operation broadcast to every cell of the sorted chain at once
    typedef struct packed {
        logic clear;    // drop all entries (end of frame)
        logic evict;    // remove the oldest entry
        logic insert;   // insert x at its sorted place
        logic ins_old;  // inserted entry is older than all others
        logic age_inc;  // surviving entries age by one
        logic shift;    // history taps advance
    } chain_op_t;

endpackage

// ===== hw/rtl/mmf_if.sv =====
// ----------------------------------------------------------------------------
// mmf_if
// Valid/ready channels for input samples and filtered results.
// ----------------------------------------------------------------------------
interface mmf_sample_if;
    import mmf_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample;
    logic    last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface mmf_median_if;
    import mmf_pkg::*;

    logic    valid;
    logic    ready;
    sample_t median_value;
    logic    last_out;

    modport source (output valid, output median_value, output last_out, input ready);
    modport sink   (input valid, input median_value, input last_out, output ready);
endinterface

// ===== hw/rtl/mmf_cell.sv =====
// ----------------------------------------------------------------------------
// mmf_cell
// One slot of the sorted window plus one history tap. Slots are kept in
// ascending (value, age) order; valid slots sit below invalid ones.
// ----------------------------------------------------------------------------
module mmf_cell #(
    parameter int IDX = 0,
    parameter int AW  = 5,
    parameter int CW  = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mmf_pkg::chain_op_t  op,
    input  mmf_pkg::sample_t    x_val,
    input  logic [AW-1:0]       x_age,
    input  mmf_pkg::sample_t    e_val,
    input  logic [AW-1:0]       e_age,
    input  logic [AW-1:0]       lo_idx,
    input  logic [AW-1:0]       hi_idx,
    input  logic [CW-1:0]       hist_idx,
    // stored slot of the right neighbor
    input  mmf_pkg::sample_t    right_val,
    input  logic [AW-1:0]       right_age,
    input  logic                right_valid,
    // compacted slot of the left neighbor
    input  mmf_pkg::sample_t    left_cval,
    input  logic [AW-1:0]       left_cage,
    input  logic                left_cvalid,
    input  logic                left_b,
    input  mmf_pkg::sample_t    left_hist,
    output mmf_pkg::sample_t    slot_val,
    output logic [AW-1:0]       slot_age,
    output logic                slot_valid,
    output mmf_pkg::sample_t    cval,
    output logic [AW-1:0]       cage,
    output logic                cvalid,
    output logic                b_out,
    output mmf_pkg::sample_t    hist_out,
    output mmf_pkg::sample_t    ev_tap,
    output mmf_pkg::sample_t    lo_tap,
    output mmf_pkg::sample_t    hi_tap,
    output mmf_pkg::sample_t    hist_tap
);
    import mmf_pkg::*;

    localparam logic [AW-1:0] MY_IDX  = AW'(IDX);
    localparam logic [CW-1:0] MY_HIDX = CW'(IDX);

    sample_t       val_reg, val_next;
    logic [AW-1:0] age_reg, age_next;
    logic          valid_reg, valid_next;
    sample_t       hist_reg, hist_next;

    logic          take_right;
    logic [AW-1:0] cage_raw;

    // at or above the evicted slot: close the gap from the right
    assign take_right = op.evict && (!valid_reg || (val_reg > e_val) || (age_reg == e_age));

    assign cval     = take_right ? right_val   : val_reg;
    assign cage_raw = take_right ? right_age   : age_reg;
    assign cvalid   = take_right ? right_valid : valid_reg;
    assign cage     = op.age_inc ? cage_raw + AW'(1) : cage_raw;

    // new entry goes before equals, an older one after them
    assign b_out = !cvalid || (op.ins_old ? (cval > x_val) : (cval >= x_val));

    always_comb
    begin
        val_next   = cval;
        age_next   = cage;
        valid_next = cvalid;
        if (op.clear)
        begin
            valid_next = 1'b0;
        end
        else if (op.insert)
        begin
            if (left_b)
            begin
                val_next   = left_cval;
                age_next   = left_cage;
                valid_next = left_cvalid;
            end
            else if (b_out)
            begin
                val_next   = x_val;
                age_next   = x_age;
                valid_next = 1'b1;
            end
        end
        hist_next = op.shift ? left_hist : hist_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        age_reg  <= age_next;
        hist_reg <= hist_next;
    end

    assign slot_val   = val_reg;
    assign slot_age   = age_reg;
    assign slot_valid = valid_reg;
    assign hist_out   = hist_reg;

    assign ev_tap   = (valid_reg && (age_reg == e_age)) ? val_reg : '0;
    assign lo_tap   = (MY_IDX == lo_idx) ? val_reg : '0;
    assign hi_tap   = (MY_IDX == hi_idx) ? val_reg : '0;
    assign hist_tap = (MY_HIDX == hist_idx) ? hist_reg : '0;

endmodule

// ===== hw/rtl/mmf_chain.sv =====
// ----------------------------------------------------------------------------
// mmf_chain
// Row of sorted-window cells with the one-hot reads of the evicted entry,
// the two middle entries and one history tap.
// ----------------------------------------------------------------------------
module mmf_chain #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int CW    = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mmf_pkg::chain_op_t  op,
    input  mmf_pkg::sample_t    new_sample,
    input  mmf_pkg::sample_t    x_val,
    input  logic [AW-1:0]       x_age,
    input  logic [AW-1:0]       e_age,
    input  logic [AW-1:0]       lo_idx,
    input  logic [AW-1:0]       hi_idx,
    input  logic [CW-1:0]       hist_idx,
    output mmf_pkg::sample_t    lo_val,
    output mmf_pkg::sample_t    hi_val,
    output mmf_pkg::sample_t    hist_val
);
    import mmf_pkg::*;

    sample_t       slot_val   [DEPTH];
    logic [AW-1:0] slot_age   [DEPTH];
    logic          slot_valid [DEPTH];
    sample_t       cval       [DEPTH];
    logic [AW-1:0] cage       [DEPTH];
    logic          cvalid     [DEPTH];
    logic          b          [DEPTH];
    sample_t       hist       [DEPTH];
    sample_t       ev_tap     [DEPTH];
    sample_t       lo_tap     [DEPTH];
    sample_t       hi_tap     [DEPTH];
    sample_t       hist_tap   [DEPTH];
    sample_t       e_val;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        sample_t       r_val, l_cval, l_hist;
        logic [AW-1:0] r_age, l_cage;
        logic          r_valid, l_cvalid, l_b;

        if (i == DEPTH - 1)
        begin : g_top_end
            assign r_val   = '0;
            assign r_age   = '0;
            assign r_valid = 1'b0;
        end
        else
        begin : g_top_mid
            assign r_val   = slot_val[i+1];
            assign r_age   = slot_age[i+1];
            assign r_valid = slot_valid[i+1];
        end

        if (i == 0)
        begin : g_bot_end
            assign l_cval   = '0;
            assign l_cage   = '0;
            assign l_cvalid = 1'b0;
            assign l_b      = 1'b0;
            assign l_hist   = new_sample;
        end
        else
        begin : g_bot_mid
            assign l_cval   = cval[i-1];
            assign l_cage   = cage[i-1];
            assign l_cvalid = cvalid[i-1];
            assign l_b      = b[i-1];
            assign l_hist   = hist[i-1];
        end

        mmf_cell #(
            .IDX (i),
            .AW  (AW),
            .CW  (CW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .op          (op),
            .x_val       (x_val),
            .x_age       (x_age),
            .e_val       (e_val),
            .e_age       (e_age),
            .lo_idx      (lo_idx),
            .hi_idx      (hi_idx),
            .hist_idx    (hist_idx),
            .right_val   (r_val),
            .right_age   (r_age),
            .right_valid (r_valid),
            .left_cval   (l_cval),
            .left_cage   (l_cage),
            .left_cvalid (l_cvalid),
            .left_b      (l_b),
            .left_hist   (l_hist),
            .slot_val    (slot_val[i]),
            .slot_age    (slot_age[i]),
            .slot_valid  (slot_valid[i]),
            .cval        (cval[i]),
            .cage        (cage[i]),
            .cvalid      (cvalid[i]),
            .b_out       (b[i]),
            .hist_out    (hist[i]),
            .ev_tap      (ev_tap[i]),
            .lo_tap      (lo_tap[i]),
            .hi_tap      (hi_tap[i]),
            .hist_tap    (hist_tap[i])
        );
    end

    // at most one cell drives each tap, the rest give zero
    always_comb
    begin
        e_val    = '0;
        lo_val   = '0;
        hi_val   = '0;
        hist_val = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            e_val    = e_val    | ev_tap[i];
            lo_val   = lo_val   | lo_tap[i];
            hi_val   = hi_val   | hi_tap[i];
            hist_val = hist_val | hist_tap[i];
        end
    end

endmodule

// ===== hw/rtl/moving_median_filter_top.sv =====
// ----------------------------------------------------------------------------
// moving_median_filter_top: sliding-window median over framed samples
// A result is registered from the updated window once the sample that releases
// it is in and the output slot is free. Throughput: 1 sample/cycle while results
// are taken and the window length holds. In a flush, results need an eviction
// first until the window is clipped to the frame. A half_width change resizes the window one entry at a time.
// Reset clears the window, sample count and state; half_width returns to 4.
// ----------------------------------------------------------------------------
module moving_median_filter_top #(
    parameter int MAX_HALF_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [mmf_pkg::CFG_W-1:0]    cfg_wr_data,
    mmf_sample_if.sink                   samples,
    mmf_median_if.source                 medians
);
    import mmf_pkg::*;

    localparam int DEPTH = 2 * MAX_HALF_WIDTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);
    localparam logic [CW-1:0] ONE     = CW'(1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } state_t;

    function automatic logic [CW-1:0] clamp_half(input logic [CFG_W-1:0] v);
        int hv;
        hv = int'(v);
        if (hv < 1)
            hv = 1;
        if (hv > MAX_HALF_WIDTH)
            hv = MAX_HALF_WIDTH;
        return CW'(hv);
    endfunction

    function automatic logic [CW-1:0] min_cnt(input logic [CW-1:0] a,
                                               input logic [CW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    state_t           state_reg, state_next;
    logic [CFG_W-1:0] half_width_reg, half_width_next;
    logic [CW-1:0]    cnt_reg, cnt_next;     // samples seen this frame, saturating
    logic [CW-1:0]    n_reg, n_next;         // entries held in the sorted window
    logic [CW-1:0]    k_reg, k_next;         // outputs left in flush (h otherwise)
    logic             last_reg, last_next;
    logic             out_valid_reg, out_valid_next;
    sample_t          median_reg, median_next;
    logic             last_out_reg, last_out_next;

    logic [CW-1:0]    h_eff, two_h, cnt_inc, len_acc, len_busy;
    logic             busy, accept, ev_acc, adj_ok, emit_need, slot_free;
    logic             emit, finish_frame, done_item;
    chain_op_t        op;
    sample_t          x_val, lo_val, hi_val, hist_val;
    logic [AW-1:0]    x_age, e_age, lo_idx, hi_idx;
    logic signed [SAMPLE_W:0] mid_sum;

    assign h_eff    = clamp_half(half_width_reg);
    assign two_h    = h_eff << 1;
    assign cnt_inc  = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + ONE;
    assign len_acc  = min_cnt(two_h, cnt_inc);
    assign ev_acc   = (n_reg >= len_acc);
    assign len_busy = min_cnt(k_reg + h_eff, cnt_reg);

    assign busy      = (state_reg == ST_BUSY);
    assign adj_ok    = (n_reg == len_busy);
    assign emit_need = last_reg || (cnt_reg >= h_eff);
    assign slot_free = !out_valid_reg || medians.ready;

    assign emit         = busy && adj_ok && emit_need && slot_free;
    assign finish_frame = emit && last_reg && (k_reg == ONE);
    assign done_item    = busy && adj_ok && !last_reg && (!emit_need || slot_free);

    assign samples.ready = (state_reg == ST_IDLE) || done_item;
    assign accept        = samples.valid && samples.ready;

    // Chain operation: an accepted sample inserts (with eviction once the
    // window is full); otherwise the window is resized one entry per cycle, or cleared at the end of a frame.
    always_comb
    begin
        op.shift   = accept;
        op.age_inc = accept;
        op.clear   = finish_frame;
        op.ins_old = !accept && busy && (n_reg < len_busy);
        op.insert  = accept || op.ins_old;
        op.evict   = accept ? ev_acc : (busy && (n_reg > len_busy));
    end

    assign x_val  = accept ? samples.sample : hist_val;
    assign x_age  = accept ? '0 : AW'(n_reg);
    assign e_age  = AW'(n_reg - ONE);
    assign lo_idx = AW'((n_reg - ONE) >> 1);
    assign hi_idx = AW'(n_reg >> 1);

    mmf_chain #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .new_sample (samples.sample),
        .x_val      (x_val),
        .x_age      (x_age),
        .e_age      (e_age),
        .lo_idx     (lo_idx),
        .hi_idx     (hi_idx),
        .hist_idx   (n_reg),
        .lo_val     (lo_val),
        .hi_val     (hi_val),
        .hist_val   (hist_val)
    );

    // floor of the mean; odd windows read the same slot twice
    assign mid_sum = {lo_val[SAMPLE_W-1], lo_val} + {hi_val[SAMPLE_W-1], hi_val};

    always_comb
    begin
        state_next      = state_reg;
        half_width_next = cfg_wr_en ? cfg_wr_data : half_width_reg;
        cnt_next        = cnt_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg;
        median_next     = median_reg;
        last_out_next   = last_out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_BUSY;
            end
            ST_BUSY:
            begin
                if (accept)
                    state_next = ST_BUSY;
                else if (done_item || finish_frame)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (accept)
        begin
            n_next    = ev_acc ? n_reg : n_reg + ONE;
            cnt_next  = cnt_inc;
            last_next = samples.last;
            k_next    = samples.last ? min_cnt(cnt_inc, h_eff) : h_eff;
        end
        else if (finish_frame)
        begin
            n_next   = '0;
            cnt_next = '0;
        end
        else if (op.evict)
        begin
            n_next = n_reg - ONE;
        end
        else if (op.ins_old)
        begin
            n_next = n_reg + ONE;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            median_next    = mid_sum[SAMPLE_W:1];
            last_out_next  = last_reg && (k_reg == ONE);
            if (last_reg && (k_reg != ONE))
                k_next = k_reg - ONE;
        end
        else if (medians.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            half_width_reg <= HALF_WIDTH_RESET;
            cnt_reg        <= '0;
            n_reg          <= '0;
            k_reg          <= '0;
            last_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            half_width_reg <= half_width_next;
            cnt_reg        <= cnt_next;
            n_reg          <= n_next;
            k_reg          <= k_next;
            last_reg       <= last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        median_reg   <= median_next;
        last_out_reg <= last_out_next;
    end

    assign medians.valid        = out_valid_reg;
    assign medians.median_value = median_reg;
    assign medians.last_out     = last_out_reg;

endmodule

// ===== hw/rtl/mmf_checker.sv =====
// ----------------------------------------------------------------------------
// mmf_checker
// Port-level checks on the median filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mmf_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             in_last,
    input logic             out_valid,
    input logic             out_ready,
    input mmf_pkg::sample_t out_median,
    input logic             out_last
);
    import mmf_pkg::*;

    // a stalled result stays up and unchanged
    `MMF_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `MMF_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_median) && $stable(out_last))

    // no new sample is taken while a frame is being flushed
    `MMF_ASSERT_NXT(a_flush_blocks_input, clk, rst_n, in_valid && in_ready && in_last, !in_ready)

    // the frame's final result leaves nothing behind it
    `MMF_ASSERT_NXT(a_frame_end_quiet, clk, rst_n, out_valid && out_ready && out_last, !out_valid)

endmodule

bind moving_median_filter_top mmf_checker u_mmf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (samples.valid),
    .in_ready   (samples.ready),
    .in_last    (samples.last),
    .out_valid  (medians.valid),
    .out_ready  (medians.ready),
    .out_median (medians.median_value),
    .out_last   (medians.last_out)
);
